/* rtl/lext_pkg.sv */
// Shared constants, types and the neighbor compare for the 3x3 local extremum detector.
package lext_pkg;

    localparam int MAX_COLS      = 32;
    localparam int SAMPLE_BITS   = 16;
    localparam int ROW_BITS      = 16;
    localparam int COL_BITS      = $clog2(MAX_COLS);
    localparam int CFG_COLS_BITS = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Result queue: two free slots per step in flight plus two for the step being taken.
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_ROOM     = FIFO_DEPTH - 4;
    localparam int FIFO_IDX_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIND_MINIMA = CFG_IDX_BITS'(0),
        CFG_COLS_IN_USE = CFG_IDX_BITS'(1),
        CFG_ROWS_IN_USE = CFG_IDX_BITS'(2)
    } t_cfg_idx;

    // One line store entry: rows r-1 (mid) and r-2 (top) at a column.
    typedef struct packed {
        t_sample mid;
        t_sample top;
    } t_pair;

    // One column of the 3x3 window.
    typedef struct packed {
        t_sample top;
        t_sample mid;
        t_sample bot;
    } t_column;

    // Position of a window step; row is the row of the bottom sample.
    typedef struct packed {
        logic                has_bot;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                row_end;
        logic                frame_end;
    } t_step;

    typedef struct packed {
        t_sample             value;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                is_ext;
        logic                last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_verdict;

    // A missing neighbor never spoils the verdict.
    function automatic logic beats(t_sample v, t_sample n, logic exists, logic find_min);
        beats = !exists || (find_min ? (v < n) : (v > n));
    endfunction

endpackage

/* rtl/lext_line_mem.sv */
// Line store: per column the two previous rows, synchronous read.
module lext_line_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [lext_pkg::COL_BITS-1:0] i_waddr,
    input  lext_pkg::t_pair               i_wdata,
    input  logic [lext_pkg::COL_BITS-1:0] i_raddr,
    output lext_pkg::t_pair               o_rdata
);
    import lext_pkg::*;

    t_pair r_mem [MAX_COLS];
    t_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lext_judge.sv */
// 3x3 window registers and the strict extremum compare for up to two pixels per step.
module lext_judge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  lext_pkg::t_step    i_step,
    input  lext_pkg::t_column  i_column,
    input  logic               i_find_minima,
    output lext_pkg::t_verdict o_res_a,
    output lext_pkg::t_verdict o_res_b
);
    import lext_pkg::*;

    t_column             r_w0;
    t_column             r_w1;
    t_column             r_w2;
    t_step               r_step;
    logic                r_step_valid;

    logic                has_top;
    logic                has_bot;
    logic                has_left_a;
    logic                ok_a;
    logic                ok_b;
    logic [ROW_BITS-1:0] center_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_valid <= 1'b0;
        end else begin
            r_step_valid <= i_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_w0   <= i_column;
            r_w1   <= r_w0;
            r_w2   <= r_w1;
            r_step <= i_step;
        end
    end

    // w0 is column c, w1 column c-1, w2 column c-2
    always_comb begin
        has_top    = r_step.row > ROW_BITS'(1);
        has_bot    = r_step.has_bot;
        has_left_a = r_step.col > COL_BITS'(1);
        center_row = r_step.row - ROW_BITS'(1);

        ok_a = beats(r_w1.mid, r_w2.top, has_left_a && has_top, i_find_minima)
            && beats(r_w1.mid, r_w2.mid, has_left_a, i_find_minima)
            && beats(r_w1.mid, r_w2.bot, has_left_a && has_bot, i_find_minima)
            && beats(r_w1.mid, r_w1.top, has_top, i_find_minima)
            && beats(r_w1.mid, r_w1.bot, has_bot, i_find_minima)
            && beats(r_w1.mid, r_w0.top, has_top, i_find_minima)
            && beats(r_w1.mid, r_w0.mid, 1'b1, i_find_minima)
            && beats(r_w1.mid, r_w0.bot, has_bot, i_find_minima);

        // last column: no right neighbors
        ok_b = beats(r_w0.mid, r_w1.top, has_top, i_find_minima)
            && beats(r_w0.mid, r_w1.mid, 1'b1, i_find_minima)
            && beats(r_w0.mid, r_w1.bot, has_bot, i_find_minima)
            && beats(r_w0.mid, r_w0.top, has_top, i_find_minima)
            && beats(r_w0.mid, r_w0.bot, has_bot, i_find_minima);

        o_res_a.valid      = r_step_valid && (r_step.row != '0) && (r_step.col != '0);
        o_res_a.res.value  = r_w1.mid;
        o_res_a.res.row    = center_row;
        o_res_a.res.col    = r_step.col - COL_BITS'(1);
        o_res_a.res.is_ext = ok_a;
        o_res_a.res.last   = 1'b0;

        o_res_b.valid      = r_step_valid && (r_step.row != '0) && r_step.row_end;
        o_res_b.res.value  = r_w0.mid;
        o_res_b.res.row    = center_row;
        o_res_b.res.col    = r_step.col;
        o_res_b.res.is_ext = ok_b;
        o_res_b.res.last   = r_step.frame_end;
    end

endmodule

/* rtl/lext_out_fifo.sv */
// Result queue: takes up to two words a cycle, hands out one.
module lext_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lext_pkg::t_verdict                 i_push_a,
    input  lext_pkg::t_verdict                 i_push_b,
    input  logic                               i_pop,
    output logic                               o_valid,
    output lext_pkg::t_result                  o_head,
    output logic [lext_pkg::FIFO_CNT_BITS-1:0] o_count
);
    import lext_pkg::*;

    t_result                  r_mem [FIFO_DEPTH];
    logic [FIFO_IDX_BITS-1:0] r_head;
    logic [FIFO_IDX_BITS-1:0] r_tail;
    logic [FIFO_CNT_BITS-1:0] r_count;

    logic [FIFO_IDX_BITS-1:0] tail_p1;
    logic [FIFO_IDX_BITS-1:0] tail_p2;
    logic [FIFO_IDX_BITS-1:0] head_p1;
    logic [FIFO_CNT_BITS-1:0] n_push;
    logic [FIFO_CNT_BITS-1:0] n_pop;

    function automatic logic [FIFO_IDX_BITS-1:0] inc(logic [FIFO_IDX_BITS-1:0] i);
        inc = (i == FIFO_IDX_BITS'(FIFO_DEPTH - 1)) ? '0 : i + FIFO_IDX_BITS'(1);
    endfunction

    always_comb begin
        tail_p1 = inc(r_tail);
        tail_p2 = inc(tail_p1);
        head_p1 = inc(r_head);
        n_push  = FIFO_CNT_BITS'(i_push_a.valid) + FIFO_CNT_BITS'(i_push_b.valid);
        n_pop   = FIFO_CNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push_a.valid) begin
                r_tail <= i_push_b.valid ? tail_p2 : tail_p1;
            end
            if (i_pop) begin
                r_head <= head_p1;
            end
            r_count <= r_count + n_push - n_pop;
        end
    end

    // b is only ever present together with a
    always_ff @(posedge i_clk) begin
        if (i_push_a.valid) begin
            r_mem[r_tail] <= i_push_a.res;
        end
        if (i_push_b.valid) begin
            r_mem[tail_p1] <= i_push_b.res;
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_head];
    assign o_count = r_count;

endmodule

/* rtl/local_extremum_3x3.sv */
// Top level of the strict 3x3 local extremum detector over a raster frame.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_stall    i_sample
//   out       source     o_out_valid / i_out_stall  o_center_value, o_center_row,
//                                                   o_center_col, o_is_extremum,
//                                                   o_frame_last
//   cfg       sink       i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// One sample a cycle while o_in_stall is low; the verdict for pixel (r-1, c-1) is formed
// in the window register once sample (r, c) is taken and leaves through the result queue.
// The frame's final sample is followed by a flush over every column with o_in_stall high,
// one last-row column read from the line store per cycle while the queue has room.
// The input also stalls while the result queue lacks room for two steps of words, so
// a stalled output backs up into the input.
// Synchronous active-low reset clears counters and queue and restores the register defaults; no line store clearing.
module local_extremum_3x3 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [lext_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [lext_pkg::SAMPLE_BITS-1:0] o_center_value,
    output logic [lext_pkg::ROW_BITS-1:0]      o_center_row,
    output logic [lext_pkg::COL_BITS-1:0]      o_center_col,
    output logic                               o_is_extremum,
    output logic                               o_frame_last,
    input  logic                               i_cfg_we,
    input  logic [lext_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [lext_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata
);
    import lext_pkg::*;

    // configuration, held as effective last indexes
    logic                     r_find_minima;
    logic [COL_BITS-1:0]      r_last_col;
    logic [ROW_BITS-1:0]      r_last_row;

    // position of the next sample; r_col doubles as the flush column
    logic [COL_BITS-1:0]      r_col;
    logic [ROW_BITS-1:0]      r_row;
    logic                     r_flush;
    logic [COL_BITS-1:0]      n_col;
    logic [ROW_BITS-1:0]      n_row;
    logic                     n_flush;

    logic                     cfg_hit;
    logic [CFG_COLS_BITS-1:0] cfg_cols;
    logic [ROW_BITS-1:0]      cfg_rows;
    logic [COL_BITS-1:0]      cfg_last_col;
    logic [ROW_BITS-1:0]      cfg_last_row;

    logic                     room;
    logic                     adv_in;
    logic                     adv_sweep;
    logic                     adv;
    logic                     row_end;
    logic                     frame_end;

    t_pair                    rd_pair;
    t_pair                    wr_pair;
    t_step                    step;
    t_column                  column;
    t_verdict                 res_a;
    t_verdict                 res_b;
    t_result                  head;
    logic                     out_valid;
    logic [FIFO_CNT_BITS-1:0] fifo_count;

    // ---------------- configuration ----------------
    always_comb begin
        cfg_cols = i_cfg_wdata[CFG_COLS_BITS-1:0];
        cfg_rows = i_cfg_wdata[ROW_BITS-1:0];

        // columns saturate into 2..MAX_COLS
        if (cfg_cols < CFG_COLS_BITS'(2)) begin
            cfg_last_col = COL_BITS'(1);
        end else if (cfg_cols > CFG_COLS_BITS'(MAX_COLS)) begin
            cfg_last_col = COL_BITS'(MAX_COLS - 1);
        end else begin
            cfg_last_col = COL_BITS'(cfg_cols - CFG_COLS_BITS'(1));
        end

        // zero or one row counts as two
        if (cfg_rows < ROW_BITS'(2)) begin
            cfg_last_row = ROW_BITS'(1);
        end else begin
            cfg_last_row = cfg_rows - ROW_BITS'(1);
        end

        unique case (i_cfg_index)
            CFG_FIND_MINIMA,
            CFG_COLS_IN_USE,
            CFG_ROWS_IN_USE: cfg_hit = i_cfg_we;
            default:         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_minima <= 1'b0;
            r_last_col    <= COL_BITS'(MAX_COLS - 1);
            r_last_row    <= ROW_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIND_MINIMA: r_find_minima <= i_cfg_wdata[0];
                CFG_COLS_IN_USE: r_last_col    <= cfg_last_col;
                CFG_ROWS_IN_USE: r_last_row    <= cfg_last_row;
                default:         ;
            endcase
        end
    end

    // ---------------- stepping ----------------
    // Each step (a sample, or one flush column) may push two words once it is in the window register.
    assign room       = fifo_count <= FIFO_CNT_BITS'(FIFO_ROOM);
    assign o_in_stall = r_flush || !room;
    assign adv_in     = i_in_valid && !o_in_stall;
    assign adv_sweep  = r_flush && room;
    assign adv        = adv_in || adv_sweep;
    assign row_end    = r_col == r_last_col;
    assign frame_end  = row_end && (r_row == r_last_row);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        if (cfg_hit) begin
            // any register write restarts the frame
            n_col   = '0;
            n_row   = '0;
            n_flush = 1'b0;
        end else if (adv_in) begin
            if (row_end) begin
                n_col = '0;
                if (frame_end) begin
                    n_row   = '0;
                    n_flush = 1'b1;
                end else begin
                    n_row = r_row + ROW_BITS'(1);
                end
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end else if (adv_sweep) begin
            if (row_end) begin
                n_col   = '0;
                n_flush = 1'b0;
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
        end
    end

    // The line store is read one column ahead (at n_col), so rd_pair always holds
    // the entry for r_col. The flush treats the frame's last row as the middle row of
    // a virtual row below it that has no bottom samples.
    always_comb begin
        wr_pair.mid = i_sample;
        wr_pair.top = rd_pair.mid;

        column.top = rd_pair.top;
        column.mid = rd_pair.mid;
        column.bot = adv_in ? i_sample : '0;

        step.has_bot   = adv_in;
        step.row       = adv_in ? r_row : r_last_row + ROW_BITS'(1);
        step.col       = r_col;
        step.row_end   = row_end;
        step.frame_end = !adv_in;
    end

    lext_line_mem u_line_mem (
        .i_clk   (i_clk),
        .i_we    (adv_in),
        .i_waddr (r_col),
        .i_wdata (wr_pair),
        .i_raddr (n_col),
        .o_rdata (rd_pair)
    );

    lext_judge u_judge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_step        (step),
        .i_column      (column),
        .i_find_minima (r_find_minima),
        .o_res_a       (res_a),
        .o_res_b       (res_b)
    );

    lext_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (res_a),
        .i_push_b (res_b),
        .i_pop    (out_valid && !i_out_stall),
        .o_valid  (out_valid),
        .o_head   (head),
        .o_count  (fifo_count)
    );

    assign o_out_valid    = out_valid;
    assign o_center_value = head.value;
    assign o_center_row   = head.row;
    assign o_center_col   = head.col;
    assign o_is_extremum  = head.is_ext;
    assign o_frame_last   = head.last;

endmodule

/* bench/tb_local_extremum_3x3.sv */
// Self-checking bench for the 3x3 local extremum detector: directed drills, random frames.
module tb_local_extremum_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import lext_pkg::*;

    localparam int ITEM_GOAL     = 410;   // no new random phase starts once this many words went in
    localparam int SETTLE_CYCLES = 8;     // pipeline depth plus margin before a reg write
    localparam int TAIL_CYCLES   = 20;    // quiet time after the last verdict
    localparam int LONG_HOLD     = 120;   // long output stall, backs up into the input
    localparam int PAUSE_AT      = 250;   // one mid-frame drain of the sender

    // Index with no register behind it; the block must ignore it.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = CFG_IDX_BITS'(3);

    // ------------------------------------------------------------------
    // DUT signals; the bench's drives are known from time zero
    // ------------------------------------------------------------------
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_sample                   i_sample    = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_sample                   o_center_value;
    logic [ROW_BITS-1:0]       o_center_row;
    logic [COL_BITS-1:0]       o_center_col;
    logic                      o_is_extremum;
    logic                      o_frame_last;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata = '0;

    local_extremum_3x3 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_center_value (o_center_value),
        .o_center_row   (o_center_row),
        .o_center_col   (o_center_col),
        .o_is_extremum  (o_is_extremum),
        .o_frame_last   (o_frame_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(4_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the detector: its own line store, position and registers
    // ------------------------------------------------------------------
    t_sample              line_copy [3][MAX_COLS];
    logic [ROW_BITS-1:0]  next_row    = '0;
    logic [COL_BITS-1:0]  next_col    = '0;
    logic                 mode_minima = 1'b0;
    logic [5:0]           cols_reg    = 6'd32;
    logic [15:0]          rows_reg    = 16'd2;

    t_result              verdicts_due [$];   // verdicts still owed by the block, oldest first
    logic [4:0]           typed_notes  [$];   // per sent word: {typed, hand-written is_ext bits}
    int                   verdicts_checked = 0;
    int                   items_sent       = 0;
    int                   failures         = 0;

    function automatic int frame_cols();
        if (cols_reg < 2) return 2;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function automatic int frame_rows();
        return (rows_reg < 2) ? 2 : int'(rows_reg);
    endfunction

    // Any real register write restarts the frame; the spare index does nothing.
    function automatic void apply_reg_write(logic [CFG_IDX_BITS-1:0] idx,
                                            logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_FIND_MINIMA: mode_minima = data[0];
            CFG_COLS_IN_USE: cols_reg = data[5:0];
            CFG_ROWS_IN_USE: rows_reg = data;
            default: return;
        endcase
        next_row = '0;
        next_col = '0;
    endfunction

    // Strict compare against every neighbor that lies inside the frame.
    function automatic t_result judge_pixel(int r, int c, logic last_px);
        t_result res;
        t_sample v;
        t_sample n;
        logic    ok;
        int      rows;
        int      cols;
        int      nr;
        int      nc;
        rows = frame_rows();
        cols = frame_cols();
        v    = line_copy[r % 3][c];
        ok   = 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = r + dr;
                nc = c + dc;
                if ((dr != 0 || dc != 0) && nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
                    n = line_copy[nr % 3][nc];
                    if (mode_minima ? !(v < n) : !(v > n))
                        ok = 1'b0;
                end
            end
        end
        res.value  = v;
        res.row    = ROW_BITS'(r);
        res.col    = COL_BITS'(c);
        res.is_ext = ok;
        res.last   = last_px;
        return res;
    endfunction

    // Queue one verdict; a typed word overrides is_ext with the hand-written bit.
    function automatic void file_verdict(t_result res, logic [4:0] note, inout int made);
        if (note[4] && made < 4)
            res.is_ext = note[made];
        verdicts_due.push_back(res);
        made++;
    endfunction

    function automatic void predict_verdicts(t_sample s, logic [4:0] note);
        int rows;
        int cols;
        int r;
        int c;
        int made;
        rows = frame_rows();
        cols = frame_cols();
        r    = int'(next_row);
        c    = int'(next_col);
        made = 0;
        line_copy[r % 3][c] = s;
        // pixel up-left is complete now; at row end also the one straight up
        if (r >= 1) begin
            if (c >= 1)
                file_verdict(judge_pixel(r - 1, c - 1, 1'b0), note, made);
            if (c == cols - 1)
                file_verdict(judge_pixel(r - 1, c, 1'b0), note, made);
        end
        // final word of the frame flushes the whole last row
        if (c == cols - 1 && r == rows - 1) begin
            for (int k = 0; k < cols; k++)
                file_verdict(judge_pixel(r, k, k == cols - 1), note, made);
            next_row = '0;
            next_col = '0;
        end else if (c + 1 >= cols) begin
            next_col = '0;
            next_row = ROW_BITS'(r + 1);
        end else begin
            next_col = COL_BITS'(c + 1);
        end
    endfunction

    function automatic void check_verdict();
        t_result want;
        if (verdicts_due.size() == 0) begin
            $error("verdict word with nothing owed: row %0d col %0d", o_center_row, o_center_col);
            failures++;
            return;
        end
        want = verdicts_due.pop_front();
        verdicts_checked++;
        if (o_center_value !== want.value) begin
            $error("center_value: expected %0d, got %0d", want.value, o_center_value);
            failures++;
        end
        if (o_center_row !== want.row) begin
            $error("center_row: expected %0d, got %0d", want.row, o_center_row);
            failures++;
        end
        if (o_center_col !== want.col) begin
            $error("center_col: expected %0d, got %0d", want.col, o_center_col);
            failures++;
        end
        if (o_is_extremum !== want.is_ext) begin
            $error("is_extremum: expected %0b, got %0b", want.is_ext, o_is_extremum);
            failures++;
        end
        if (o_frame_last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, o_frame_last);
            failures++;
        end
    endfunction

    // Monitor: everything sampled at the edge that does the handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                apply_reg_write(i_cfg_index, i_cfg_wdata);
            if (i_in_valid && !o_in_stall)
                predict_verdicts(i_sample, (typed_notes.size() != 0) ?
                                 typed_notes.pop_front() : 5'b0);
            if (o_out_valid && !i_out_stall)
                check_verdict();
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, calm stretches, two long hold-offs
    // ------------------------------------------------------------------
    initial begin : out_side
        int stall_run;
        int calm_run;
        int holds_done;
        int roll;
        stall_run  = 0;
        calm_run   = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (stall_run > 0) begin
                stall_run--;
            end else if (calm_run > 0) begin
                calm_run--;
            end else if (i_in_valid && ((holds_done == 0 && verdicts_checked >= 60) ||
                                        (holds_done == 1 && verdicts_checked >= 300))) begin
                // sender keeps offering while we sit, so the block must stall its input
                stall_run = LONG_HOLD;
                holds_done++;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    calm_run = $urandom_range(0, 4);
                else if (roll < 85)
                    stall_run = $urandom_range(1, 3);
                else if (roll < 95)
                    calm_run = $urandom_range(20, 80);
                else
                    stall_run = $urandom_range(10, 40);
            end
            i_out_stall <= (stall_run > 0);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    // style 0: full range, 1: small values with many ties, else: extremes and values around zero
    function automatic t_sample pick_value(int style);
        t_sample v;
        int      t;
        if (style == 0) begin
            v = t_sample'($urandom);
        end else if (style == 1) begin
            t = int'($urandom_range(0, 4)) - 2;
            v = t_sample'(t);
        end else begin
            case ($urandom_range(0, 4))
                0:       v = 16'sh8000;
                1:       v = 16'sh7FFF;
                2:       v = 16'sh0000;
                3:       v = 16'shFFFF;
                default: v = 16'sh0001;
            endcase
        end
        return v;
    endfunction

    task automatic send_sample(t_sample s, logic [4:0] note, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed_notes.push_back(note);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Stop sending and wait until every owed verdict came back.
    task automatic drain_verdicts(int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes land only on an idle block; the extra edge lets the shadow catch up.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        drain_verdicts(SETTLE_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Maybe a new mode and new frame geometry for a random phase, unless the old ones are kept; mostly small frames.
    task automatic pick_settings(logic must_restart);
        logic [15:0] word;
        int          cols_eff;
        int          roll;
        if (!must_restart && $urandom_range(0, 4) == 0)
            return;
        if ($urandom_range(0, 1)) begin
            word = 16'($urandom);
            write_reg(CFG_FIND_MINIMA, word);
        end
        // upper data bits are junk on purpose
        word = 16'($urandom) & 16'hFFC0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            word[5:0] = 6'($urandom_range(2, 6));
        else if (roll < 77)
            word[5:0] = 6'($urandom_range(7, 16));
        else if (roll < 87)
            word[5:0] = 6'd32;
        else if (roll < 94)
            word[5:0] = 6'($urandom_range(0, 1));
        else
            word[5:0] = 6'($urandom_range(33, 63));
        cols_eff = (word[5:0] < 2) ? 2 : ((word[5:0] > MAX_COLS) ? MAX_COLS : int'(word[5:0]));
        write_reg(CFG_COLS_IN_USE, word);
        roll = $urandom_range(0, 99);
        if (roll < 8)
            word = 16'($urandom_range(1000, 65535));   // never completes, cut short
        else if (roll < 18)
            word = 16'($urandom_range(0, 1));
        else if (cols_eff > 8)
            word = 16'($urandom_range(2, 3));
        else if (roll < 85)
            word = 16'($urandom_range(2, 4));
        else
            word = 16'($urandom_range(5, 8));
        write_reg(CFG_ROWS_IN_USE, word);
    endtask

    // ------------------------------------------------------------------
    // Directed drills: tiny frames at the extremes, saturating register
    // values, an ignored index and a frame cut short by a write.
    // typed rows carry the is_ext bits of the step's verdicts, oldest in bit 0.
    // ------------------------------------------------------------------
    typedef enum logic {DRILL_SAMPLE, DRILL_REG} t_drill_kind;

    typedef struct packed {
        t_drill_kind             kind;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [15:0]             word;
        logic                    typed;
        logic [3:0]              ext_mask;
    } t_drill;

    localparam int DRILL_COUNT = 29;

    t_drill drills [DRILL_COUNT] = '{
        // cols 1 with junk high bits -> 2, rows 0 -> 2
        '{DRILL_REG,    CFG_COLS_IN_USE, 16'hFFC1, 1'b0, 4'b0000},
        '{DRILL_REG,    CFG_ROWS_IN_USE, 16'h0000, 1'b0, 4'b0000},
        // 2x2 maxima: top-left peak at max value
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h7FFF, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h8000, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h8000, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h8000, 1'b1, 4'b0001},
        // 2x2 flat frame: ties never make an extremum
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'hFFFF, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'hFFFF, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'hFFFF, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'hFFFF, 1'b1, 4'b0000},
        // minima mode, only bit 0 of the data counts
        '{DRILL_REG,    CFG_FIND_MINIMA, 16'h8001, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h8000, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h0000, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h0000, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h7FFF, 1'b1, 4'b0001},
        '{DRILL_REG,    CFG_SPARE_IDX,   16'hFFFF, 1'b0, 4'b0000},
        // cols 63 -> 32, rows at top of range; frame gets cut by the next write
        '{DRILL_REG,    CFG_COLS_IN_USE, 16'h003F, 1'b0, 4'b0000},
        '{DRILL_REG,    CFG_ROWS_IN_USE, 16'hFFFF, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h1234, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'hFFFB, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h7FFF, 1'b0, 4'b0000},
        // 3 columns, rows 1 -> 2
        '{DRILL_REG,    CFG_COLS_IN_USE, 16'h0003, 1'b0, 4'b0000},
        '{DRILL_REG,    CFG_ROWS_IN_USE, 16'h0001, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h0010, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'hFFF0, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h0010, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h0011, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h0012, 1'b0, 4'b0000},
        '{DRILL_SAMPLE, CFG_FIND_MINIMA, 16'h0013, 1'b0, 4'b0000}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int   frames;
        int   len;
        int   cap;
        int   style;
        logic burst;
        logic partial;
        logic cut_short;
        logic paused;
        cut_short = 1'b0;
        paused    = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DRILL_COUNT; i++) begin
            if (drills[i].kind == DRILL_REG)
                write_reg(drills[i].idx, drills[i].word);
            else
                send_sample(t_sample'(drills[i].word),
                            {drills[i].typed, drills[i].ext_mask}, pick_gap());
        end

        // Random phases of frames, some cut short; a frame cut short forces a restart write.
        while (items_sent < ITEM_GOAL) begin
            pick_settings(cut_short);
            cut_short = 1'b0;
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames && !cut_short; f++) begin
                len     = frame_cols() * frame_rows();
                partial = (frame_rows() > 8) || ($urandom_range(0, 9) == 0);
                if (partial) begin
                    cap = 2 * frame_cols() + 3;
                    if (cap > len - 1)
                        cap = len - 1;
                    len = $urandom_range(1, cap);
                end
                style = $urandom_range(0, 2);
                burst = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < len; k++) begin
                    if (!paused && items_sent >= PAUSE_AT) begin
                        drain_verdicts(0);
                        paused = 1'b1;
                    end
                    send_sample(pick_value(style), 5'b0, burst ? 0 : pick_gap());
                end
                cut_short = partial;
            end
        end

        drain_verdicts(TAIL_CYCLES);
        if (verdicts_due.size() != 0) begin
            $error("%0d verdicts never arrived", verdicts_due.size());
            failures++;
        end
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
